>>> design/murmur3_stream_hash_core_defines.svh
// Assertion macros shared by the checker.
`ifndef MURMUR3_STREAM_HASH_CORE_DEFINES_SVH
`define MURMUR3_STREAM_HASH_CORE_DEFINES_SVH

// cons follows from ante in the next cycle.
`define MM3_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("mm3 check failed: next-cycle property");

// sig holds its value in the cycle after cond.
`define MM3_ASSERT_HOLD(label, clk, dis, cond, sig) \
    label: assert property (@(posedge clk) disable iff (dis) (cond) |=> $stable(sig)) \
        else $error("mm3 check failed: value not held");

`endif

>>> design/mm3_pkg.sv
`timescale 1ns / 1ps

package mm3_pkg;

    localparam logic [31:0] MIX_C1     = 32'hCC9E2D51;
    localparam logic [31:0] MIX_C2     = 32'h1B873593;
    localparam logic [31:0] FOLD_ADD   = 32'hE6546B64;
    localparam logic [31:0] AVAL_M1    = 32'h85EBCA6B;
    localparam logic [31:0] AVAL_M2    = 32'hC2B2AE35;
    localparam logic [31:0] SEED_RESET = 32'h93C467E3;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [31:0] word;     // masked to the valid bytes
        logic [2:0]  count;    // 0 to 4
        logic        finish;   // ends the message
    } q_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_FOLD,
        ST_AVAL1,
        ST_AVAL2,
        ST_EMIT
    } back_state_t;

endpackage

>>> design/mm3_front.sv
`timescale 1ns / 1ps

module mm3_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mm3_pkg::S_TDATA_W-1:0]   s_tdata,    // data_word[31:0], byte_count[34:32]
    input  logic                            s_tlast,
    output logic                            push_valid,
    input  logic                            push_ready,
    output mm3_pkg::q_item_t                push_item
);

    logic             in_valid_reg;
    logic             in_valid_next;
    mm3_pkg::q_item_t item_reg;
    mm3_pkg::q_item_t item_next;
    logic [2:0]       count_sat;
    logic [31:0]      word_in;

    assign word_in   = s_tdata[31:0];
    assign count_sat = (s_tdata[34:32] > mm3_pkg::FULL_COUNT) ? mm3_pkg::FULL_COUNT
                                                             : s_tdata[34:32];

    assign s_tready   = !in_valid_reg || push_ready;
    assign push_valid = in_valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_next     = item_reg;
        in_valid_next = in_valid_reg;
        if (in_valid_reg && push_ready) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next    = 1'b1;
            item_next.count  = count_sat;
            item_next.finish = s_tlast || (count_sat != mm3_pkg::FULL_COUNT);
            case (count_sat)
                3'd0:    item_next.word = 32'h0;
                3'd1:    item_next.word = {24'h0, word_in[7:0]};
                3'd2:    item_next.word = {16'h0, word_in[15:0]};
                3'd3:    item_next.word = {8'h0, word_in[23:0]};
                default: item_next.word = word_in;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        item_reg <= item_next;
    end

endmodule

>>> design/mm3_queue.sv
`timescale 1ns / 1ps

module mm3_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  mm3_pkg::q_item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mm3_pkg::q_item_t pop_item
);

    mm3_pkg::q_item_t                      slot_reg [mm3_pkg::QUEUE_DEPTH];
    logic [mm3_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [mm3_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [mm3_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [mm3_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [mm3_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [mm3_pkg::QUEUE_CNT_W-1:0]       count_next;
    logic                                  do_push;
    logic                                  do_pop;

    assign push_ready = (count_reg != mm3_pkg::QUEUE_CNT_W'(mm3_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/mm3_back.sv
`timescale 1ns / 1ps

module mm3_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [31:0]                     seed,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  mm3_pkg::q_item_t                pop_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mm3_pkg::M_TDATA_W-1:0]   m_tdata     // hash[31:0], total_length[63:32]
);

    mm3_pkg::back_state_t state_reg;
    mm3_pkg::back_state_t state_next;

    logic [31:0] k_reg,        k_next;
    logic [2:0]  cnt_reg,      cnt_next;
    logic        fin_reg,      fin_next;
    logic [31:0] hash_reg,     hash_next;
    logic [31:0] len_reg,      len_next;
    logic        at_start_reg, at_start_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic [31:0] out_len_reg,  out_len_next;

    logic [31:0] k_rot;
    logic [31:0] mix;
    logic [31:0] mix_rot;
    logic [31:0] fold;
    logic [31:0] av1;
    logic [31:0] av2;

    assign k_rot   = {k_reg[16:0], k_reg[31:17]};
    assign mix     = hash_reg ^ k_reg;
    assign mix_rot = {mix[18:0], mix[31:19]};
    assign fold    = {mix_rot[29:0], 2'b00} + mix_rot + mm3_pkg::FOLD_ADD;
    assign av1     = (hash_reg ^ len_reg) ^ ((hash_reg ^ len_reg) >> 16);
    assign av2     = hash_reg ^ (hash_reg >> 13);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_hash_reg};

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        hash_next      = hash_reg;
        len_next       = len_reg;
        at_start_next  = at_start_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        out_len_next   = out_len_reg;
        pop_ready      = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            mm3_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    k_next   = pop_item.word;
                    cnt_next = pop_item.count;
                    fin_next = pop_item.finish;
                    if (at_start_reg) begin
                        hash_next     = seed;
                        len_next      = '0;
                        at_start_next = 1'b0;
                    end
                    state_next = mm3_pkg::ST_MIX1;
                end
            end
            mm3_pkg::ST_MIX1: begin
                k_next     = k_reg * mm3_pkg::MIX_C1;
                state_next = mm3_pkg::ST_MIX2;
            end
            mm3_pkg::ST_MIX2: begin
                k_next     = k_rot * mm3_pkg::MIX_C2;
                state_next = mm3_pkg::ST_FOLD;
            end
            mm3_pkg::ST_FOLD: begin
                hash_next  = (cnt_reg == mm3_pkg::FULL_COUNT) ? fold : mix;
                len_next   = len_reg + {29'h0, cnt_reg};
                state_next = fin_reg ? mm3_pkg::ST_AVAL1 : mm3_pkg::ST_IDLE;
            end
            mm3_pkg::ST_AVAL1: begin
                hash_next  = av1 * mm3_pkg::AVAL_M1;
                state_next = mm3_pkg::ST_AVAL2;
            end
            mm3_pkg::ST_AVAL2: begin
                hash_next  = av2 * mm3_pkg::AVAL_M2;
                state_next = mm3_pkg::ST_EMIT;
            end
            mm3_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_hash_next  = hash_reg ^ (hash_reg >> 16);
                    out_len_next   = len_reg;
                    out_valid_next = 1'b1;
                    at_start_next  = 1'b1;
                    state_next     = mm3_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mm3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mm3_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            at_start_reg  <= at_start_next;
            out_valid_reg <= out_valid_next;
        end
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        fin_reg      <= fin_next;
        hash_reg     <= hash_next;
        len_reg      <= len_next;
        out_hash_reg <= out_hash_next;
        out_len_reg  <= out_len_next;
    end

endmodule

>>> design/murmur3_stream_hash_core.sv
`timescale 1ns / 1ps
// MurmurHash3 (x86_32) of a byte message streamed as little-endian 32-bit words.
// Input channel s_*: one word per transaction, byte_count of 4 for a full word,
// 0 to 3 for a short final word; s_tlast or a short word ends the message.
// Output channel m_*: one transaction per finished message with the hash and
// the byte length. cfg_wr_en/cfg_wr_data load the seed, used at each message start.
// Sequencer: the back sequencer fetches, runs two multiply steps and folds each
// word before it takes the next; a message end adds the avalanche and output load.
// A 4-entry queue between front register and sequencer absorbs bursts.
// The last word reaches m_tvalid through front register, queue and sequencer.
// Reset: queue and registers empty, s_tready high, m_tvalid low, seed back to
// 0x93C467E3, next word starts a new message.
// Stall: a finished result waits in the output register while the sequencer
// keeps working; it blocks only when a second result is ready, and s_tready
// drops once the queue and front register fill.
module murmur3_stream_hash_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mm3_pkg::S_TDATA_W-1:0]   s_tdata,    // data_word[31:0], byte_count[34:32]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mm3_pkg::M_TDATA_W-1:0]   m_tdata,    // hash[31:0], total_length[63:32]
    input  logic                            cfg_wr_en,
    input  logic [31:0]                     cfg_wr_data
);

    logic [31:0]      seed_reg;
    logic             push_valid;
    logic             push_ready;
    mm3_pkg::q_item_t push_item;
    logic             pop_valid;
    logic             pop_ready;
    mm3_pkg::q_item_t pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= mm3_pkg::SEED_RESET;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    mm3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mm3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mm3_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed      (seed_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> design/mm3_checker.sv
`timescale 1ns / 1ps
`include "murmur3_stream_hash_core_defines.svh"

module mm3_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mm3_pkg::M_TDATA_W-1:0]   m_tdata
);

    // reset empties the output register and the front register
    `MM3_ASSERT_NEXT(a_rst_no_result, aclk, 1'b0, !aresetn, !m_tvalid)
    `MM3_ASSERT_NEXT(a_rst_ready, aclk, 1'b0, !aresetn, s_tready)
    // a stalled result stays put
    `MM3_ASSERT_NEXT(a_valid_held, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid)
    `MM3_ASSERT_HOLD(a_data_held, aclk, !aresetn, m_tvalid && !m_tready, m_tdata)

endmodule

bind murmur3_stream_hash_core mm3_checker u_mm3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/murmur3_stream_hash_core_tb.sv
`timescale 1ns / 1ps

class murmur_checker;
    typedef struct {
        bit [31:0] hash;
        bit [31:0] length;
    } digest_t;

    bit [31:0] seed;
    bit [31:0] run_hash;
    bit [31:0] byte_total;
    bit        at_start;
    digest_t   pending_digests[$];
    int        mismatches;
    int        hashes_checked;

    function new();
        seed           = mm3_pkg::SEED_RESET;
        run_hash       = '0;
        byte_total     = '0;
        at_start       = 1'b1;
        mismatches     = 0;
        hashes_checked = 0;
    endfunction

    function bit [31:0] rol(bit [31:0] v, int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function bit [31:0] scramble_word(bit [31:0] k);
        bit [31:0] t;
        t = k * mm3_pkg::MIX_C1;
        t = rol(t, 15);
        return t * mm3_pkg::MIX_C2;
    endfunction

    function bit [31:0] finalize(bit [31:0] h);
        bit [31:0] t;
        t = h ^ (h >> 16);
        t = t * mm3_pkg::AVAL_M1;
        t = t ^ (t >> 13);
        t = t * mm3_pkg::AVAL_M2;
        return t ^ (t >> 16);
    endfunction

    // One accepted input transaction; queues a digest when the message ends.
    function void note_word(bit [31:0] word, bit [2:0] count_in, bit last);
        bit [2:0]  count;
        bit [31:0] mask;
        digest_t   d;
        count = (count_in > mm3_pkg::FULL_COUNT) ? mm3_pkg::FULL_COUNT : count_in;
        if (at_start) begin
            run_hash   = seed;
            byte_total = '0;
            at_start   = 1'b0;
        end
        if (count == mm3_pkg::FULL_COUNT) begin
            run_hash   = run_hash ^ scramble_word(word);
            run_hash   = rol(run_hash, 13) * 32'd5 + mm3_pkg::FOLD_ADD;
            byte_total = byte_total + 32'd4;
            if (!last) begin
                return;
            end
        end else if (count != 3'd0) begin
            mask       = (32'd1 << (8 * count)) - 32'd1;
            run_hash   = run_hash ^ scramble_word(word & mask);
            byte_total = byte_total + 32'(count);
        end
        d.hash   = finalize(run_hash ^ byte_total);
        d.length = byte_total;
        pending_digests.push_back(d);
        at_start = 1'b1;
    endfunction

    function void check_result(bit [mm3_pkg::M_TDATA_W-1:0] tdata);
        digest_t d;
        hashes_checked++;
        if (pending_digests.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: hash %h len %0d", tdata[31:0], tdata[63:32]);
            end
            return;
        end
        d = pending_digests.pop_front();
        if (tdata[31:0] !== d.hash || tdata[63:32] !== d.length) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected hash %h len %0d, got hash %h len %0d",
                         d.hash, d.length, tdata[31:0], tdata[63:32]);
            end
        end
    endfunction

    function int pending();
        return pending_digests.size();
    endfunction
endclass

module murmur3_stream_hash_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 64;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mm3_pkg::S_TDATA_W-1:0] s_tdata = '0;     // data_word[31:0], byte_count[34:32]
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mm3_pkg::M_TDATA_W-1:0] m_tdata;          // hash[31:0], total_length[63:32]
    logic                          cfg_wr_en = 1'b0;
    logic [31:0]                   cfg_wr_data = '0;

    murmur_checker checker_h = new();
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            words_sent = 0;
    int            seeds_used = 1;
    longint        cycles = 0;

    murmur3_stream_hash_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check accepted transactions, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            checker_h.check_result(m_tdata);
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(bit [31:0] word, bit [2:0] count, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(mm3_pkg::S_TDATA_W-35){1'b0}}, count, word};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        checker_h.note_word(word, count, last);
        words_sent++;
    endtask

    function automatic bit [2:0] full_count();
        return ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : mm3_pkg::FULL_COUNT;
    endfunction

    task automatic send_message();
        int r;
        int nwords;
        r = $urandom_range(99);
        if (r < 70) begin
            nwords = $urandom_range(0, 4);
        end else if (r < 95) begin
            nwords = $urandom_range(5, 12);
        end else begin
            nwords = $urandom_range(20, 40);
        end
        for (int i = 0; i < nwords; i++) begin
            send_word($urandom(), full_count(), 1'b0);
        end
        if ($urandom_range(99) < 45) begin
            send_word($urandom(), 3'($urandom_range(0, 3)), 1'($urandom_range(1)));
        end else begin
            send_word($urandom(), full_count(), 1'b1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (checker_h.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(bit [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        checker_h.seed = value;
        seeds_used++;
    endtask

    task automatic run_phase(int n_words, int idle_pct, int stall_pct, bit leave_open);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = words_sent + n_words;
        while (words_sent < target) begin
            send_message();
        end
        // open message carried over a seed write
        if (leave_open) begin
            send_word($urandom(), mm3_pkg::FULL_COUNT, 1'b0);
            send_word($urandom(), mm3_pkg::FULL_COUNT, 1'b0);
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty, short, saturated counts, all-ones and all-zero words
        send_word(32'hFFFFFFFF, 3'd0, 1'b1);
        send_word(32'hFFFFFFFF, 3'd0, 1'b0);
        send_word(32'hA5A5A5A5, 3'd1, 1'b1);
        send_word(32'hFFFFFFFF, 3'd2, 1'b0);
        send_word(32'hFFFFFFFF, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        send_word(32'h01234567, 3'd4, 1'b0);
        send_word(32'h89ABCDEF, 3'd7, 1'b0);
        send_word(32'hDEADBEEF, 3'd3, 1'b0);
        send_word(32'h55555555, 3'd5, 1'b0);
        send_word(32'hAAAAAAAA, 3'd6, 1'b1);
        send_word(32'h00000000, 3'd3, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b0);
        drain();

        write_seed(32'h00000000);
        run_phase(220, 0, 0, 1'b1);
        write_seed(32'hFFFFFFFF);
        run_phase(110, 63, 0, 1'b0);
        run_phase(110, 63, 0, 1'b0);
        write_seed($urandom());
        run_phase(220, 0, 63, 1'b1);
        write_seed($urandom());
        run_phase(220, 9, 9, 1'b0);

        $display("covered %0d input transactions, %0d hashes, %0d seeds incl. mid-message",
                 words_sent, checker_h.hashes_checked, seeds_used);
        $display("changes, empty/short/saturated-count words, %0d mismatches",
                 checker_h.mismatches);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
